### design/hvuc_pkg.sv
// Package for the hint section unpack and check block.
// Holds widths, reset values, register indexes, the controller state type and
// the command/status structs shared by hvuc_ctrl, hvuc_dp and the top level.
package hvuc_pkg;

	localparam int unsigned MAX_HINTS_DEF = 80;
	localparam int unsigned MAX_POLYS_DEF = 8;
	localparam int unsigned COEFFS        = 256;
	localparam int unsigned WORD_W        = 64;
	localparam int unsigned WORDS         = COEFFS / WORD_W;
	localparam int unsigned WIDX_W        = $clog2(WORDS);
	localparam int unsigned CNT_W         = 7;
	localparam int unsigned POLY_W        = 3;
	localparam int unsigned PCNT_W        = 4;
	localparam int unsigned CFG_W         = 7;
	localparam int unsigned BYTE_W        = 8;

	localparam logic [PCNT_W-1:0] POLY_COUNT_RST = 4'd6;
	localparam logic [CNT_W-1:0]  HINT_LIMIT_RST = 7'd55;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	typedef enum logic [0:0] {
		REG_POLY_COUNT = 1'b0,
		REG_HINT_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan;
		logic emit;
		logic fail;
	} dp_cmd_t;

	typedef struct packed {
		logic go_walk;
		logic scan_done;
		logic scan_err;
		logic word_last;
	} dp_stat_t;

endpackage

### design/hvuc_ctrl.sv
// Controller state machine of the hint section unpack and check block.
// Depends on hvuc_pkg; sequences the datapath hvuc_dp by command and status.
module hvuc_ctrl
	import hvuc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output logic     busy,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		busy      = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = start;
				if (start && stat.go_walk) begin
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.scan = 1'b1;
				if (stat.scan_done) begin
					if (stat.scan_err) begin
						cmd.fail  = 1'b1;
						state_nxt = ST_IDLE;
					end else begin
						state_nxt = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (stat.word_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

### design/hvuc_dp.sv
// Datapath of the hint section unpack and check block: config registers,
// position store, section counters, scan pipeline, hint map and result register.
// Depends on hvuc_pkg; driven by hvuc_ctrl.
module hvuc_dp
	import hvuc_pkg::*;
#(
	parameter int unsigned MAX_HINTS = MAX_HINTS_DEF,
	parameter int unsigned MAX_POLYS = MAX_POLYS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_stat_t          stat,
	input  logic [BYTE_W-1:0] hint_byte,
	input  logic              first,
	input  logic              cfg_write,
	input  cfg_reg_t          cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	output logic              strobe,
	output logic [POLY_W-1:0] poly_index,
	output logic [WIDX_W-1:0] word_index,
	output logic [WORD_W-1:0] hint_bits,
	output logic              status,
	output logic              last,
	output logic              done_res
);

	localparam int unsigned AW = (MAX_HINTS > 1) ? $clog2(MAX_HINTS) : 1;
	localparam logic [CNT_W:0]    HINTS_CAP = (CNT_W + 1)'(MAX_HINTS);
	localparam logic [PCNT_W-1:0] POLYS_CAP = PCNT_W'(MAX_POLYS);
	localparam logic [WIDX_W-1:0] WORD_LAST = WIDX_W'(WORDS - 1);

	logic [PCNT_W-1:0] poly_count_q;
	logic [CNT_W-1:0]  hint_limit_q;
	logic [CNT_W-1:0]  byte_count_q;
	logic [CNT_W-1:0]  prev_end_q;
	logic [POLY_W-1:0] poly_ctr_q;
	logic              rejected_q;

	logic [CNT_W-1:0]  end_q;
	logic [CNT_W-1:0]  scan_end_q;
	logic [CNT_W-1:0]  j_q;
	logic              final_q;
	logic              err_q;
	logic [WIDX_W-1:0] word_q;
	logic [WORDS-1:0][WORD_W-1:0] map_q;
	logic [BYTE_W-1:0] prev_pos_q;

	logic [BYTE_W-1:0] mem [MAX_HINTS];
	logic [BYTE_W-1:0] rdata_s1;
	logic              rd_valid_s1;
	logic              rd_first_s1;
	logic              rd_inmap_s1;

	logic [CNT_W-1:0]  omega;
	logic [PCNT_W-1:0] polys;
	logic [CNT_W-1:0]  bc_eff;
	logic [CNT_W-1:0]  pe_eff;
	logic [POLY_W-1:0] pc_eff;
	logic              rej_eff;
	logic              is_pos;
	logic [CNT_W-1:0]  pidx;
	logic              in_range;
	logic              count_bad;
	logic              is_final;
	logic              store_wr;
	logic              reject_now;
	logic              issue;

	// Effective register values: saturate out-of-range settings.
	always_comb begin
		omega = ({1'b0, hint_limit_q} > HINTS_CAP) ? HINTS_CAP[CNT_W-1:0] : hint_limit_q;
		if (poly_count_q == '0) begin
			polys = PCNT_W'(1);
		end else if (poly_count_q > POLYS_CAP) begin
			polys = POLYS_CAP;
		end else begin
			polys = poly_count_q;
		end
	end

	// Section state as seen by this beat: a first flag clears it.
	assign bc_eff  = first ? '0 : byte_count_q;
	assign pe_eff  = first ? '0 : prev_end_q;
	assign pc_eff  = first ? '0 : poly_ctr_q;
	assign rej_eff = first ? 1'b0 : rejected_q;

	assign is_pos    = (bc_eff < omega);
	assign pidx      = bc_eff - omega;
	assign in_range  = (pidx < CNT_W'(polys));
	assign count_bad = ({1'b0, pe_eff} > hint_byte) || (hint_byte > {1'b0, omega});
	assign is_final  = ((pidx + CNT_W'(1)) == CNT_W'(polys));

	assign store_wr   = cmd.accept && !rej_eff && is_pos;
	assign reject_now = cmd.accept && !rej_eff && !is_pos && in_range && count_bad;
	assign issue      = cmd.scan && (j_q < scan_end_q);

	assign stat.go_walk   = !rej_eff && !is_pos && in_range && !count_bad;
	assign stat.scan_done = (j_q == scan_end_q) && !rd_valid_s1;
	assign stat.scan_err  = err_q;
	assign stat.word_last = (word_q == WORD_LAST);

	// Config and section control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_count_q <= POLY_COUNT_RST;
			hint_limit_q <= HINT_LIMIT_RST;
			byte_count_q <= '0;
			prev_end_q   <= '0;
			poly_ctr_q   <= '0;
			rejected_q   <= 1'b0;
			rd_valid_s1  <= 1'b0;
			err_q        <= 1'b0;
			strobe       <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_POLY_COUNT: poly_count_q <= cfg_data[PCNT_W-1:0];
					REG_HINT_LIMIT: hint_limit_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.accept && first) begin
				byte_count_q <= '0;
				prev_end_q   <= '0;
				poly_ctr_q   <= '0;
				rejected_q   <= 1'b0;
			end
			if (store_wr) begin
				byte_count_q <= bc_eff + CNT_W'(1);
			end
			if (reject_now || cmd.fail) begin
				rejected_q <= 1'b1;
			end
			if (cmd.emit && stat.word_last) begin
				prev_end_q   <= end_q;
				poly_ctr_q   <= poly_ctr_q + POLY_W'(1);
				byte_count_q <= byte_count_q + CNT_W'(1);
			end
			rd_valid_s1 <= issue;
			if (cmd.accept) begin
				err_q <= 1'b0;
			end else if (rd_valid_s1) begin
				if (rd_inmap_s1) begin
					if (!rd_first_s1 && (rdata_s1 <= prev_pos_q)) begin
						err_q <= 1'b1;
					end
				end else if (rdata_s1 != '0) begin
					err_q <= 1'b1;
				end
			end
			strobe <= cmd.emit || reject_now || cmd.fail;
		end
	end

	// Position store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (store_wr) begin
			mem[bc_eff[AW-1:0]] <= hint_byte;
		end
		rdata_s1 <= mem[j_q[AW-1:0]];
	end

	// Scan walk, hint map and result payload.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			end_q      <= hint_byte[CNT_W-1:0];
			final_q    <= is_final;
			scan_end_q <= is_final ? omega : hint_byte[CNT_W-1:0];
			j_q        <= pe_eff;
			map_q      <= '0;
			word_q     <= '0;
		end
		if (issue) begin
			j_q         <= j_q + CNT_W'(1);
			rd_first_s1 <= (j_q == prev_end_q);
			rd_inmap_s1 <= (j_q < end_q);
		end
		if (rd_valid_s1) begin
			prev_pos_q <= rdata_s1;
			if (rd_inmap_s1) begin
				map_q[rdata_s1[7:6]][rdata_s1[5:0]] <= 1'b1;
			end
		end
		if (cmd.emit) begin
			word_q     <= word_q + WIDX_W'(1);
			poly_index <= poly_ctr_q;
			word_index <= word_q;
			hint_bits  <= map_q[word_q];
			status     <= STATUS_OK;
			last       <= stat.word_last;
			done_res   <= stat.word_last && final_q;
		end else if (reject_now || cmd.fail) begin
			poly_index <= reject_now ? pc_eff : poly_ctr_q;
			word_index <= '0;
			hint_bits  <= '0;
			status     <= STATUS_BAD;
			last       <= 1'b1;
			done_res   <= 1'b1;
		end
	end

	a_bad_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == STATUS_BAD) |-> last && done_res && (hint_bits == '0))
		else $error("malformed result must close the section");

	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == STATUS_OK) |-> (last == (word_index == WORD_LAST)))
		else $error("last must mark word three of a polynomial");

	a_words_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == STATUS_OK) && (word_index != WORD_LAST)
		|=> strobe && (status == STATUS_OK)
			&& (word_index == $past(word_index) + WIDX_W'(1)))
		else $error("hint words of one polynomial must follow back to back");

	a_no_store_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> !store_wr && !cfg_write)
		else $error("store or config written during a scan");

endmodule

### design/hint_vector_unpack_check.sv
// Hint section unpack and check. Feed the hint section one byte per beat
// (start high while busy is low); raise first on the first byte of each
// signature. The first hint_limit bytes are positions and are taken while
// busy stays low. Each following count byte is accepted, then walks the
// position store through a single registered read port, one stored entry
// per cycle, over the positions of this polynomial (and on the final
// polynomial also over the unused tail, which must be zero). After the last
// read the read data is registered, then the order and tail check is
// registered. Then it puts out the four 64-bit words of the hint map in
// order. A malformed count is rejected at once with a single result, a
// malformed position order or tail after the walk. Results appear on the
// strobe for exactly one cycle each and cannot be stalled: the receiver must
// take every beat. The user must write configuration (poly_count at index 0,
// hint_limit at index 1) only while the block is idle; the block itself does
// not enforce it. The position store has no reset; it holds whatever was
// last written.
module hint_vector_unpack_check
	import hvuc_pkg::*;
#(
	parameter int unsigned MAX_HINTS = MAX_HINTS_DEF,
	parameter int unsigned MAX_POLYS = MAX_POLYS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// input beats
	input  logic              start,
	output logic              busy,
	input  logic [BYTE_W-1:0] hint_byte,
	input  logic              first,
	// configuration writes
	input  logic              cfg_write,
	input  cfg_reg_t          cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// result beats
	output logic              strobe,
	output logic [POLY_W-1:0] poly_index,
	output logic [WIDX_W-1:0] word_index,
	output logic [WORD_W-1:0] hint_bits,
	output logic              status,
	output logic              last,
	output logic              done_res
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Controller: accept beats, run the store walk, drive the four word beats.
	hvuc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Datapath: store positions, check ordering and tail, build the hint map.
	hvuc_dp #(
		.MAX_HINTS (MAX_HINTS),
		.MAX_POLYS (MAX_POLYS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.hint_byte  (hint_byte),
		.first      (first),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.strobe     (strobe),
		.poly_index (poly_index),
		.word_index (word_index),
		.hint_bits  (hint_bits),
		.status     (status),
		.last       (last),
		.done_res   (done_res)
	);

endmodule
